@@ design/frame_bitmap_run_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Frame bitmap run allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_RUN_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// checked while out of reset
`define FBRA_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("frame allocator assertion failed");
// checked on every edge, reset included
`define FBRA_ASSERT_ALL(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("frame allocator assertion failed");
`else
`define FBRA_ASSERT(name, clk, rstn, prop)
`define FBRA_ASSERT_ALL(name, clk, prop)
`endif

`endif

@@ design/fbra_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame bitmap run allocator package
// Item types, operation and state codes, reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fbra_pkg;

  localparam int unsigned FrameCountDef = 32768;
  localparam int unsigned WordBitsDef   = 32;
  localparam int unsigned PageBytes     = 4096;
  localparam logic [15:0] LimitReset    = 16'd16384;
  localparam logic [15:0] FloorReset    = 16'(32'h0300_0000 / PageBytes);

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_RANGE,
    ST_ABOVE,
    ST_DONE
  } state_e;

  // register index, taken from paddr[2]
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  typedef struct packed {
    mode_e       mode;
    logic [14:0] first_frame;
    logic [15:0] frame_count;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [14:0] run_start;
    logic [15:0] used_total;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/frame_bitmap_run_allocator.sv @@
// ----------------------------------------------------------------------------
// Frame bitmap run allocator
// First-fit contiguous page frame allocator over a one-bit-per-frame map.
// ----------------------------------------------------------------------------
// One command item at a time: start is taken while busy is low, and exactly
// one result item follows on result_o, marked by result_valid_o for a single
// cycle; the receiver cannot stall it, so it must sample that cycle. The map
// sits in one memory of FRAME_COUNT/WORD_BITS words with a registered read
// port, and every phase streams it one word per cycle. An item runs through
// the allocate scan (stopping on a hit), the range update and the recount of
// the words at or above the frame limit, each only where it applies, and then
// the result. The words above the limit are recounted on every item while
// the limit lies below the map size, to report used frames below the limit.
// After reset the map is filled with ones, one pass over all its
// FRAME_COUNT/WORD_BITS words (1024 by default), during which busy stays
// high; config writes are taken during that pass.
// WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_bitmap_run_allocator_macros.svh"

module frame_bitmap_run_allocator #(
  parameter int unsigned FRAME_COUNT = fbra_pkg::FrameCountDef,
  parameter int unsigned WORD_BITS   = fbra_pkg::WordBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command
  input  wire logic               start,
  output logic                    busy,
  input  wire fbra_pkg::in_item_t item_i,
  output logic                    result_valid_o,
  output fbra_pkg::out_item_t     result_o,
  // config
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import fbra_pkg::*;

  localparam int unsigned FW        = $clog2(FRAME_COUNT + 1);
  localparam int unsigned EW        = (FW > 17) ? FW : 17;
  localparam int unsigned MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW        = $clog2(WORD_BITS);
  localparam int unsigned CW        = $clog2(WORD_BITS + 1);
  localparam logic [EW-1:0] FrameMax = EW'(FRAME_COUNT);
  localparam logic [WA:0]   LastWord = (WA + 1)'(MAP_WORDS - 1);

  function automatic logic [WA:0] wrd(input logic [EW-1:0] f);
    logic [EW-1:0] s;
    s = f >> BW;
    return s[WA:0];
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [15:0]     limit_q, floor_q;
  logic [FW-1:0]   cnt_q, cnt_d;          // used frames over the whole map
  logic [FW-1:0]   above_q, above_d;      // used frames at or above limit
  logic [EW-1:0]   run_q, run_d;          // free run carried between words
  logic [EW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [EW-1:0]   need_q, need_d;        // requested frame count
  logic            set_q, set_d;
  logic            status_q, status_d;
  logic [14:0]     start_q, start_d;
  logic [WA:0]     nxt_q, nxt_d, end_q, end_d;
  logic            rv_q;                  // read data valid this cycle
  logic [WA-1:0]   rv_addr_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  // memory port controls
  logic                 issue;
  logic                 mem_we;
  logic [WA-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // clamped config
  logic [EW-1:0] lim, flr;
  assign lim = (EW'(limit_q) > FrameMax) ? FrameMax : EW'(limit_q);
  assign flr = (EW'(floor_q) > FrameMax) ? FrameMax : EW'(floor_q);

  // request decode
  logic          acc;
  logic [EW-1:0] req_lo, req_hi, req_sum, req_first;
  logic          zero_req, alloc_ok, range_ok, above_ok;

  assign acc       = start && !busy;
  assign req_first = EW'(item_i.first_frame);
  assign req_sum   = req_first + EW'(item_i.frame_count);
  assign req_lo    = (item_i.mode == MODE_FREE && flr > req_first) ? flr : req_first;
  assign req_hi    = (req_sum > lim) ? lim : req_sum;
  assign zero_req  = (item_i.frame_count == 16'd0);
  assign alloc_ok  = (flr < lim);
  assign range_ok  = (req_lo < req_hi);
  assign above_ok  = (lim < FrameMax);

  // --------------------------------------------------------------------------
  // per-word datapath
  // --------------------------------------------------------------------------
  logic [EW-1:0]        base;
  logic [WORD_BITS-1:0] elig, free_m, rmask, flip_m, above_m;
  logic [EW-1:0]        run_v [WORD_BITS];
  logic                 hit_any, hit;
  logic [EW-1:0]        hit_b, cand;
  logic [CW-1:0]        flips, above_cnt;
  logic                 phase_end, init_end;

  assign base = EW'({rv_addr_q, {BW{1'b0}}});

  always_comb begin
    logic          fb;
    logic [EW-1:0] br;
    for (int b = 0; b < WORD_BITS; b++) begin
      elig[b]    = (base + EW'(b) >= flr) && (base + EW'(b) < lim);
      rmask[b]   = (base + EW'(b) >= lo_q) && (base + EW'(b) < hi_q);
      above_m[b] = (base + EW'(b) >= lim) && rdata_q[b];
    end
    free_m = elig & ~rdata_q;
    // length of the free run ending at each bit
    for (int b = 0; b < WORD_BITS; b++) begin
      fb = 1'b0;
      br = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j <= b && !free_m[j]) begin
          fb = 1'b1;
          br = EW'(j);
        end
      end
      run_v[b] = fb ? (EW'(b) - br) : (run_q + EW'(b) + EW'(1));
    end
    hit_any = 1'b0;
    hit_b   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!hit_any && free_m[b] && run_v[b] >= need_q) begin
        hit_any = 1'b1;
        hit_b   = EW'(b);
      end
    end
    flip_m    = set_q ? (rmask & ~rdata_q) : (rmask & rdata_q);
    flips     = '0;
    above_cnt = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      flips     = flips + CW'(flip_m[b]);
      above_cnt = above_cnt + CW'(above_m[b]);
    end
  end

  assign hit       = (state_q == ST_ALLOC) && rv_q && hit_any;
  assign cand      = base + hit_b + EW'(1) - need_q;
  assign phase_end = !rv_q && (nxt_q > end_q);
  assign init_end  = (nxt_q == LastWord);

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (zero_req) begin
            state_d = above_ok ? ST_ABOVE : ST_DONE;
          end else if (item_i.mode == MODE_ALLOC) begin
            state_d = alloc_ok ? ST_ALLOC : (above_ok ? ST_ABOVE : ST_DONE);
          end else begin
            state_d = range_ok ? ST_RANGE : (above_ok ? ST_ABOVE : ST_DONE);
          end
        end
      end
      ST_ALLOC: begin
        if (hit) state_d = ST_RANGE;
        else if (phase_end) state_d = above_ok ? ST_ABOVE : ST_DONE;
      end
      ST_RANGE: begin
        if (phase_end) state_d = above_ok ? ST_ABOVE : ST_DONE;
      end
      ST_ABOVE: begin
        if (phase_end) state_d = ST_DONE;
      end
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_d     = cnt_q;
    above_d   = above_q;
    run_d     = run_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    need_d    = need_q;
    set_d     = set_q;
    status_d  = status_q;
    start_d   = start_q;
    nxt_d     = nxt_q;
    end_d     = end_q;
    mem_we    = 1'b0;
    mem_waddr = rv_addr_q;
    mem_wdata = rdata_q;
    issue     = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = nxt_q[WA-1:0];
        mem_wdata = '1;
        nxt_d     = nxt_q + (WA + 1)'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          need_d   = EW'(item_i.frame_count);
          status_d = zero_req || (item_i.mode == MODE_ALLOC);
          start_d  = '0;
          above_d  = '0;
          lo_d     = req_lo;
          hi_d     = req_hi;
          set_d    = (item_i.mode == MODE_RESERVE);
        end
      end
      ST_ALLOC: begin
        issue = (nxt_q <= end_q) && !hit;
        if (rv_q) begin
          if (hit_any) begin
            // run ends at the hit bit
            lo_d     = cand;
            hi_d     = base + hit_b + EW'(1);
            set_d    = 1'b1;
            status_d = 1'b0;
            start_d  = cand[14:0];
          end else begin
            run_d = free_m[WORD_BITS-1] ? run_v[WORD_BITS-1] : '0;
          end
        end
      end
      ST_RANGE: begin
        issue = (nxt_q <= end_q);
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_wdata = set_q ? (rdata_q | rmask) : (rdata_q & ~rmask);
          if (set_q) cnt_d = cnt_q + FW'(flips);
          else cnt_d = (cnt_q >= FW'(flips)) ? cnt_q - FW'(flips) : '0;
        end
      end
      ST_ABOVE: begin
        issue = (nxt_q <= end_q);
        if (rv_q) above_d = above_q + FW'(above_cnt);
      end
      default: ;
    endcase

    if (issue) nxt_d = nxt_q + (WA + 1)'(1);

    // phase setup on entry
    if (state_d != state_q) begin
      case (state_d)
        ST_ALLOC: begin
          nxt_d = wrd(flr);
          end_d = wrd(lim - EW'(1));
          run_d = '0;
        end
        ST_RANGE: begin
          nxt_d = wrd(lo_d);
          end_d = wrd(hi_d - EW'(1));
        end
        ST_ABOVE: begin
          nxt_d = wrd(lim);
          end_d = LastWord;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      limit_q <= LimitReset;
      floor_q <= FloorReset;
      cnt_q   <= FW'(FRAME_COUNT);
      nxt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nxt_q   <= nxt_d;
      rv_q    <= issue;
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_LIMIT: limit_q <= pwdata[15:0];
          REG_FLOOR: floor_q <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    above_q   <= above_d;
    run_q     <= run_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    need_q    <= need_d;
    set_q     <= set_d;
    status_q  <= status_d;
    start_q   <= start_d;
    end_q     <= end_d;
    rv_addr_q <= nxt_q[WA-1:0];
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[nxt_q[WA-1:0]];
  end

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  logic [FW-1:0] used;
  assign used = (cnt_q >= above_q) ? cnt_q - above_q : '0;

  assign busy                = (state_q != ST_IDLE);
  assign result_valid_o      = (state_q == ST_DONE);
  assign result_o.status     = status_q;
  assign result_o.run_start  = start_q;
  assign result_o.used_total = 16'(used);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FLOOR) ? {16'd0, floor_q} : {16'd0, limit_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `FBRA_ASSERT(a_result_while_busy, clk_i, rst_ni, result_valid_o |-> busy)
  `FBRA_ASSERT(a_accept_goes_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `FBRA_ASSERT(a_single_result, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
  `FBRA_ASSERT_ALL(a_no_write_idle, clk_i, (state_q == ST_IDLE) |-> !mem_we)

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Frame bitmap run allocator testbench
// Drives allocate, free, reserve and release items through the command port
// and sets the frame limit and protected floor over the register port. Each
// result item is checked field by field against a bitmap model kept here.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbra_pkg::*;

  localparam int unsigned MapFrames = 32768;
  localparam int unsigned WatchLimit = 40000;  // full scan + recount + fill pass, several times
  localparam logic [2:0] AddrLimit = {REG_LIMIT, 2'b00};
  localparam logic [2:0] AddrFloor = {REG_FLOOR, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    item_i = '0;
  logic        result_valid_o;
  out_item_t   result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_bitmap_run_allocator u_top (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---- frame map model ----------------------------------------------------
  bit        frame_used[MapFrames];
  int        map_used_count;
  bit [15:0] limit_reg;
  bit [15:0] floor_reg;
  out_item_t pending_results[$];
  int        fail_count = 0;
  int        sender_idle_pct = 0;
  int        idle_cycles = 0;

  function automatic void mark_frame(int f, bit used);
    if (f >= MapFrames) return;
    if (used && !frame_used[f]) begin
      frame_used[f] = 1'b1;
      map_used_count++;
    end else if (!used && frame_used[f]) begin
      frame_used[f] = 1'b0;
      if (map_used_count > 0) map_used_count--;
    end
  endfunction

  // Applies one item to the map and returns the result it must produce.
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    int lim, flr, run, cand, stop, above, f;
    bit found;
    lim = (limit_reg > MapFrames) ? MapFrames : limit_reg;
    flr = (floor_reg > MapFrames) ? MapFrames : floor_reg;
    r = '0;
    found = 1'b0;
    run = 0;
    cand = 0;
    above = 0;
    if (it.frame_count == 0) begin
      r.status = 1'b1;
    end else if (it.mode == MODE_ALLOC) begin
      r.status = 1'b1;
      for (f = flr; f < lim && !found; f++) begin
        if (!frame_used[f]) begin
          if (run == 0) cand = f;
          run++;
          if (run == it.frame_count) found = 1'b1;
        end else begin
          run = 0;
        end
      end
      if (found) begin
        for (f = cand; f < cand + it.frame_count; f++) mark_frame(f, 1'b1);
        r.run_start = cand[14:0];
        r.status = 1'b0;
      end
    end else begin
      stop = it.first_frame + it.frame_count;
      if (stop > lim) stop = lim;
      for (f = it.first_frame; f < stop; f++) begin
        if (it.mode == MODE_FREE) begin
          if (f >= flr) mark_frame(f, 1'b0);
        end else begin
          mark_frame(f, it.mode == MODE_RESERVE);
        end
      end
    end
    for (f = lim; f < MapFrames; f++) if (frame_used[f]) above++;
    r.used_total = (map_used_count >= above) ? 16'(map_used_count - above) : 16'd0;
    return r;
  endfunction

  // ---- result checker and watchdog ---------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      idle_cycles <= (result_valid_o || (start && !busy)) ? 0 : idle_cycles + 1;
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          $error("result item with none expected");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_o.status);
            fail_count++;
          end
          if (result_o.run_start !== want.run_start) begin
            $error("run_start: expected %0d, got %0d", want.run_start, result_o.run_start);
            fail_count++;
          end
          if (result_o.used_total !== want.used_total) begin
            $error("used_total: expected %0d, got %0d", want.used_total,
                   result_o.used_total);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no item accepted for %0d cycles", WatchLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---- drivers ------------------------------------------------------------
  // Start stays high between back-to-back items; it drops only for a gap or a drain.
  task automatic send_item(mode_e m, int first, int count);
    in_item_t it;
    it.mode = m;
    it.first_frame = first[14:0];
    it.frame_count = count[15:0];
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_item(it));
  endtask

  // Drop start and wait for every outstanding result.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Setup and access cycles; the caller closes the transfer.
  task automatic write_reg(logic [2:0] addr, bit [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == AddrLimit) limit_reg = value;
    else floor_reg = value;
  endtask

  task automatic set_window(bit [15:0] lim, bit [15:0] flr);
    write_reg(AddrLimit, lim);
    write_reg(AddrFloor, flr);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // ---- tests --------------------------------------------------------------
  // Map comes out of reset fully used: allocate fails, zero counts fail.
  task automatic test_reset_state();
    send_item(MODE_ALLOC, 0, 1);
    send_item(MODE_ALLOC, 0, 0);
    send_item(MODE_FREE, 100, 0);
    send_item(MODE_RESERVE, 100, 0);
    send_item(MODE_RELEASE, 100, 0);
    drain();
  endtask

  // Release opens frames, allocate takes first fit, free and reserve edit.
  task automatic test_alloc_free();
    set_window(16'd4096, 16'd1024);
    send_item(MODE_RELEASE, 0, 4096);
    send_item(MODE_ALLOC, 0, 1);
    send_item(MODE_ALLOC, 32767, 100);
    send_item(MODE_RESERVE, 1200, 8);
    send_item(MODE_ALLOC, 0, 200);        // must skip the reserved hole
    send_item(MODE_FREE, 0, 1100);        // frame zero start, floor skips low frames
    send_item(MODE_FREE, 4000, 500);      // clamped at the limit
    send_item(MODE_RELEASE, 4096, 10);    // starts at the limit: no effect
    send_item(MODE_ALLOC, 0, 65535);      // no fitting run
    send_item(MODE_ALLOC, 0, 32768);
    drain();
  endtask

  // Register extremes: limit zero, floor above limit, values past the map.
  task automatic test_window_extremes();
    set_window(16'd0, 16'd0);
    send_item(MODE_RELEASE, 0, 50);
    send_item(MODE_ALLOC, 0, 1);
    drain();
    set_window(16'd2048, 16'd3000);
    send_item(MODE_ALLOC, 0, 1);
    send_item(MODE_FREE, 2000, 40);
    drain();
    set_window(16'hFFFF, 16'hFFFF);
    send_item(MODE_RELEASE, 32760, 100);
    send_item(MODE_ALLOC, 0, 1);
    send_item(MODE_FREE, 32700, 100);
    drain();
    set_window(16'd32768, 16'd0);
    send_item(MODE_ALLOC, 0, 4);
    send_item(MODE_RESERVE, 32767, 1);
    drain();
  endtask

  // Random items inside a window, mostly short runs near the window.
  task automatic test_random(bit [15:0] lim, bit [15:0] flr, int idle_pct, int n);
    int lo, hi, first, count, pick;
    mode_e m;
    sender_idle_pct = idle_pct;
    set_window(lim, flr);
    lo = (flr > MapFrames) ? MapFrames : flr;
    hi = (lim > MapFrames) ? MapFrames : lim;
    if (lo > 64) lo = lo - 64; else lo = 0;
    hi = hi + 64;
    if (hi > MapFrames - 1) hi = MapFrames - 1;
    if (lo > hi) lo = hi;
    send_item(MODE_RELEASE, lo, hi - lo + 1);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) m = MODE_ALLOC;
      else if (pick < 65) m = MODE_FREE;
      else if (pick < 80) m = MODE_RESERVE;
      else m = MODE_RELEASE;
      first = ($urandom_range(9) < 7) ? $urandom_range(hi, lo) : $urandom_range(32767);
      pick = $urandom_range(99);
      if (pick < 80) count = $urandom_range(64, 1);
      else if (pick < 95) count = $urandom_range(2048, 1);
      else count = $urandom_range(65535);
      send_item(m, first, count);
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int f = 0; f < MapFrames; f++) frame_used[f] = 1'b1;
    map_used_count = MapFrames;
    limit_reg = LimitReset;
    floor_reg = FloorReset;
    @(posedge clk_i);
    test_reset_state();
    test_alloc_free();
    test_window_extremes();
    test_random(16'd4096, 16'd1024, 21, 190);
    test_random(16'd16384, 16'd12288, 83, 190);
    test_random(16'd32768, 16'd0, 0, 190);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/fbra_pkg.sv
design/frame_bitmap_run_allocator.sv
sim/tb.sv
